// ===== rtl/kssp_pkg.sv =====
`default_nettype none
package kssp_pkg;

	// pool geometry
	localparam int CAPACITY = 16;
	localparam int STACKS   = 4;

	// slot pointer holds CAPACITY as the null mark
	localparam int SLOT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int STK_W  = $clog2(STACKS);
	localparam int DATA_W = 32;

	// stream widths, rounded up to whole bytes
	localparam int IN_BITS  = 2 + 2 + DATA_W;
	localparam int OUT_BITS = DATA_W + 2 + 1;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [SLOT_W-1:0] NIL_SLOT = SLOT_W'(CAPACITY);

	typedef enum logic [1:0] {
		ACT_PUSH = 2'd0,
		ACT_POP  = 2'd1,
		ACT_TOP  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]               action;
		logic [1:0]               stack_index;
		logic signed [DATA_W-1:0] push_value;
	} op_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		status_t                  status;
		logic                     now_empty;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/kssp_pool.sv =====
`default_nettype none
module kssp_pool
	import kssp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire op_t  op,
	output res_t      res,
	output logic      pool_full
);

	logic [SLOT_W-1:0] link_q [CAPACITY];
	logic [SLOT_W-1:0] head_q [STACKS];
	logic [SLOT_W-1:0] free_q;
	logic [DATA_W-1:0] data_q [CAPACITY];

	logic [STK_W-1:0]  sidx;
	logic [SLOT_W-1:0] head;
	logic              head_valid;
	logic              free_valid;
	logic [IDX_W-1:0]  head_idx;
	logic [IDX_W-1:0]  free_idx;
	logic [SLOT_W-1:0] link_rd;
	logic [SLOT_W-1:0] new_head;
	logic              stack_ok;
	logic              do_push;
	logic              do_pop;

	always_comb begin
		sidx       = op.stack_index[STK_W-1:0];
		head       = head_q[sidx];
		head_valid = head < NIL_SLOT;
		free_valid = free_q < NIL_SLOT;
		head_idx   = head[IDX_W-1:0];
		free_idx   = free_q[IDX_W-1:0];
		stack_ok   = int'(op.stack_index) < STACKS;
		// one link read per operation: push follows the free list, pop the stack
		link_rd    = (op.action == ACT_PUSH) ? link_q[free_idx] : link_q[head_idx];

		do_push          = 1'b0;
		do_pop           = 1'b0;
		res.result_value = '0;
		res.status       = ST_OK;

		case (op.action)
			ACT_PUSH: begin
				if (free_valid) do_push = 1'b1;
				else res.status = ST_OVERFLOW;
			end
			ACT_POP: begin
				if (head_valid) begin
					do_pop           = 1'b1;
					res.result_value = data_q[head_idx];
				end else begin
					res.status = ST_UNDERFLOW;
				end
			end
			ACT_TOP: begin
				if (head_valid) res.result_value = data_q[head_idx];
				else res.status = ST_UNDERFLOW;
			end
			default: ;
		endcase

		// stack number beyond the pool's stacks
		if (!stack_ok) begin
			do_push          = 1'b0;
			do_pop           = 1'b0;
			res.result_value = '0;
			res.status       = ST_UNDERFLOW;
		end

		new_head      = do_push ? free_q : (do_pop ? link_rd : head);
		res.now_empty = !(new_head < NIL_SLOT) || !stack_ok;
		pool_full     = !free_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) link_q[i] <= SLOT_W'(i + 1);
			for (int j = 0; j < STACKS; j++) head_q[j] <= NIL_SLOT;
			free_q <= '0;
		end else if (step) begin
			if (do_push) begin
				free_q           <= link_rd;
				link_q[free_idx] <= head;
				head_q[sidx]     <= free_q;
			end else if (do_pop) begin
				head_q[sidx]     <= link_rd;
				link_q[head_idx] <= free_q;
				free_q           <= head;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && do_push) data_q[free_idx] <= op.push_value;
	end

endmodule
`default_nettype wire

// ===== rtl/k_stacks_shared_pool_unit.sv =====
`default_nettype none
// Several LIFO stacks sharing one pool of CAPACITY slots, linked through a free
// list. Each transaction on the slave stream is one operation (push, pop or read
// top) on one stack and yields exactly one transaction on the master stream with
// the popped or top value, a status (ok, overflow when the pool is full, underflow
// on an empty stack) and whether the addressed stack is empty afterwards. The unit
// takes one operation every clock cycle; each operation passes through the input
// register, then the result register, before its result appears. That rate comes
// from the pool's flop-based link, head and data arrays, which are read and updated
// in one pass per operation. No clearing pass follows reset: the unit is ready at
// once. Operations stall only when the result register is full and not taken.
module k_stacks_shared_pool_unit
	import kssp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	// slave stream: operations
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,  // action[1:0], stack_index[3:2], push_value[35:4]
	// master stream: results
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata   // result_value[31:0], status[33:32], now_empty[34]
);

	op_t  op_in;
	op_t  op_s1;
	logic vld_s1;
	res_t res;
	res_t res_q;
	logic m_vld_q;
	logic advance;
	logic pool_full;

	// unpack the incoming transaction, lowest field first
	always_comb begin
		op_in.action      = s_tdata[1:0];
		op_in.stack_index = s_tdata[3:2];
		op_in.push_value  = s_tdata[4 +: DATA_W];
	end

	// the held operation moves on when the result register is free or being drained
	assign advance  = vld_s1 && (!m_vld_q || m_tready);
	assign s_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			m_vld_q <= 1'b0;
		end else begin
			if (s_tready) vld_s1 <= s_tvalid;
			if (advance) m_vld_q <= 1'b1;
			else if (m_tready) m_vld_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) op_s1 <= op_in;
		if (advance) res_q <= res;
	end

	// pool state and its single-pass update
	kssp_pool u_pool (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.op        (op_s1),
		.res       (res),
		.pool_full (pool_full)
	);

	assign m_tvalid = m_vld_q;
	assign m_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, res_q.now_empty, res_q.status,
		res_q.result_value};

`ifndef SYNTH
	// a successful pop always leaves at least one free slot
	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1.action == ACT_POP && res.status == ST_OK |=> !pool_full)
		else $error("pool still full after a pop");

	// a successful push leaves its stack non-empty
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1.action == ACT_PUSH && res.status == ST_OK |-> !res.now_empty)
		else $error("stack empty after a push");

	// overflow is reported only when the pool really is full
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.status == ST_OVERFLOW |-> pool_full)
		else $error("overflow with free slots left");

	// an empty result register never blocks a new operation
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!m_vld_q |-> s_tready)
		else $error("input stalled with result register empty");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
import kssp_pkg::*;

module testbench;

	// receiver behavior
	localparam int RX_ALWAYS  = 0;
	localparam int RX_RANDOM  = 1;
	localparam int RX_PATTERN = 2;

	// action code that the block leaves undefined
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// cycles with no transaction on either side before giving up
	localparam int STUCK_LIMIT = 3000;
	// long receiver hold-off, in cycles
	localparam int LONG_HOLD = 120;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	k_stacks_shared_pool_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // action[1:0], stack_index[3:2], push_value[35:4]
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // result_value[31:0], status[33:32], now_empty[34]
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mirror of the pool: slot values, slot links, stack heads, free list head
	logic signed [DATA_W-1:0] pool_val  [CAPACITY];
	logic [SLOT_W-1:0]        pool_next [CAPACITY];
	logic [SLOT_W-1:0]        chain_top [STACKS];
	logic [SLOT_W-1:0]        free_top;

	// answers the block owes, oldest first
	res_t stack_answers [$];
	res_t head_res;

	// sender and receiver pacing knobs
	int  rx_mode = RX_ALWAYS;
	bit  tx_bursty = 1'b0;
	int  burst_left = 0;
	int  hold_ask = 0;
	int  hold_left = 0;
	int  rx_cycle = 0;

	// bookkeeping
	int n_errors = 0;
	int n_checked = 0;
	int n_push = 0, n_pop = 0, n_top = 0, n_unused = 0;
	int n_overflow = 0, n_underflow = 0;
	int stuck_cycles = 0;

	// pool after reset: every slot chained on the free list, all stacks empty
	task automatic pool_reset();
		for (int i = 0; i < CAPACITY; i++) begin
			pool_val[i]  = '0;
			pool_next[i] = (i + 1 < CAPACITY) ? SLOT_W'(i + 1) : NIL_SLOT;
		end
		for (int k = 0; k < STACKS; k++)
			chain_top[k] = NIL_SLOT;
		free_top = '0;
	endtask

	// apply one operation to the mirror and return the answer it must give
	function automatic res_t pool_apply(logic [1:0] act, logic [1:0] stk,
			logic signed [DATA_W-1:0] val);
		res_t r;
		logic [SLOT_W-1:0] s;
		r.result_value = '0;
		r.status = ST_OK;
		r.now_empty = 1'b1;
		// out-of-range stack: nothing moves, reported as underflow
		if (stk >= STACKS) begin
			r.status = ST_UNDERFLOW;
			return r;
		end
		case (act)
			ACT_PUSH: begin
				s = free_top;
				if (s >= CAPACITY) begin
					r.status = ST_OVERFLOW;
				end else begin
					free_top = pool_next[s[IDX_W-1:0]];
					pool_next[s[IDX_W-1:0]] = chain_top[stk];
					chain_top[stk] = s;
					pool_val[s[IDX_W-1:0]] = val;
				end
			end
			ACT_POP: begin
				s = chain_top[stk];
				if (s >= CAPACITY) begin
					r.status = ST_UNDERFLOW;
				end else begin
					chain_top[stk] = pool_next[s[IDX_W-1:0]];
					pool_next[s[IDX_W-1:0]] = free_top;
					free_top = s;
					r.result_value = pool_val[s[IDX_W-1:0]];
				end
			end
			ACT_TOP: begin
				s = chain_top[stk];
				if (s >= CAPACITY)
					r.status = ST_UNDERFLOW;
				else
					r.result_value = pool_val[s[IDX_W-1:0]];
			end
			default: ;  // unused code: no change, status ok
		endcase
		r.now_empty = (chain_top[stk] >= CAPACITY);
		return r;
	endfunction

	// one line per mismatch, capped so a broken block cannot flood the log
	task automatic report_mismatch(string what, longint got, longint want);
		n_errors++;
		if (n_errors <= 40)
			$display("mismatch on result %0d: %s got %0d expected %0d",
				n_checked, what, got, want);
	endtask

	// offer one operation and hold it until the block takes it
	task automatic send_op(logic [1:0] act, logic [1:0] stk, logic signed [DATA_W-1:0] val);
		res_t r;
		bit took;
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'({val, stk, act});
		// ready is stable between edges, so the falling edge tells what the next rising edge does
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
		r = pool_apply(act, stk, val);
		stack_answers.push_back(r);
		case (act)
			ACT_PUSH: n_push++;
			ACT_POP:  n_pop++;
			ACT_TOP:  n_top++;
			default:  n_unused++;
		endcase
		if (r.status == ST_OVERFLOW)
			n_overflow++;
		if (r.status == ST_UNDERFLOW)
			n_underflow++;
	endtask

	// in bursty mode, bursts of random length with random gaps between them
	task automatic pace();
		if (tx_bursty) begin
			if (burst_left == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 10);
			end
			burst_left--;
		end
	endtask

	// stop offering and wait until every owed answer has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (stack_answers.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// random data with the extremes mixed in
	function automatic logic signed [DATA_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0:       return 32'sh7fffffff;
			1:       return 32'sh80000000;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// empty stacks, extremes of the data, each action, the unused code
	task automatic test_directed();
		rx_mode = RX_ALWAYS;
		tx_bursty = 1'b0;
		send_op(ACT_TOP, 2'd0, 32'sh0);          // top on empty stack
		send_op(ACT_POP, 2'd3, 32'sh0);          // pop on empty stack
		send_op(ACT_UNUSED, 2'd1, 32'sh0);       // unused code, empty stack
		send_op(ACT_PUSH, 2'd0, 32'sh7fffffff);
		send_op(ACT_PUSH, 2'd0, 32'sh80000000);
		send_op(ACT_TOP, 2'd0, 32'sh0);
		send_op(ACT_UNUSED, 2'd0, 32'sh7fffffff); // unused code, stack not empty
		send_op(ACT_PUSH, 2'd1, 32'shffffffff);
		send_op(ACT_PUSH, 2'd2, 32'sh0);
		send_op(ACT_PUSH, 2'd3, 32'shaaaaaaaa);
		send_op(ACT_PUSH, 2'd3, 32'sh55555555);
		send_op(ACT_TOP, 2'd3, 32'shffffffff);    // push value ignored
		send_op(ACT_POP, 2'd3, 32'sh0);
		send_op(ACT_POP, 2'd3, 32'sh0);
		send_op(ACT_POP, 2'd3, 32'sh0);          // now empty again
		send_op(ACT_POP, 2'd2, 32'sh0);
		send_op(ACT_POP, 2'd1, 32'sh0);
		send_op(ACT_POP, 2'd0, 32'sh0);
		send_op(ACT_POP, 2'd0, 32'sh0);
		send_op(ACT_TOP, 2'd1, 32'sh0);
		send_op(ACT_POP, 2'd1, 32'sh12345678);
		send_op(ACT_UNUSED, 2'd3, 32'sh80000000);
		drain();
	endtask

	// fill the whole pool, push into a full pool, then empty every stack
	task automatic test_fill_and_empty(bit bursty);
		int depth [STACKS];
		int k;
		rx_mode = RX_RANDOM;
		tx_bursty = bursty;
		for (int i = 0; i < STACKS; i++)
			depth[i] = 0;
		repeat (CAPACITY) begin
			k = $urandom_range(0, STACKS - 1);
			depth[k]++;
			pace();
			send_op(ACT_PUSH, 2'(k), rand_word());
		end
		repeat (3) begin
			pace();
			send_op(ACT_PUSH, 2'($urandom_range(0, STACKS - 1)), rand_word());  // overflow
		end
		pace();
		send_op(ACT_TOP, 2'($urandom_range(0, STACKS - 1)), rand_word());
		// one extra pop per stack runs into underflow
		for (int i = 0; i < STACKS; i++) begin
			repeat (depth[i] + 1) begin
				pace();
				send_op(ACT_POP, 2'(i), rand_word());
			end
		end
		drain();
	endtask

	// receiver stops for a long stretch while the sender keeps offering
	task automatic test_backpressure();
		rx_mode = RX_ALWAYS;
		tx_bursty = 1'b0;
		hold_ask = LONG_HOLD;
		repeat (40) begin
			case ($urandom_range(0, 2))
				0: send_op(ACT_PUSH, 2'($urandom_range(0, STACKS - 1)), rand_word());
				1: send_op(ACT_POP, 2'($urandom_range(0, STACKS - 1)), rand_word());
				default: send_op(ACT_TOP, 2'($urandom_range(0, STACKS - 1)), rand_word());
			endcase
		end
		drain();
	endtask

	// random operations, weighted so the pool drifts full or empty
	task automatic test_random_traffic(int count, int push_pct, int pop_pct, int rxm, bit bursty);
		int pick;
		logic [1:0] act;
		rx_mode = rxm;
		tx_bursty = bursty;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < push_pct)
				act = ACT_PUSH;
			else if (pick < push_pct + pop_pct)
				act = ACT_POP;
			else if (pick < 96)
				act = ACT_TOP;
			else
				act = ACT_UNUSED;
			pace();
			send_op(act, 2'($urandom_range(0, STACKS - 1)), rand_word());
		end
		drain();
	endtask

	// receiver: long hold-off on request, otherwise its own stall pattern
	always @(posedge clk) begin
		rx_cycle++;
		if (hold_ask != 0) begin
			hold_left = hold_ask;
			hold_ask = 0;
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_RANDOM:  m_tready <= ($urandom_range(0, 9) < 6);
				RX_PATTERN: m_tready <= ((rx_cycle % 7) > 2);
				default:    m_tready <= 1'b1;
			endcase
		end
	end

	// result checker: each result against the oldest owed answer
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			n_checked++;
			if (stack_answers.size() == 0) begin
				report_mismatch("result with nothing owed, value", $signed(m_tdata[31:0]), 0);
			end else begin
				head_res = stack_answers.pop_front();
				if (m_tdata[31:0] !== head_res.result_value)
					report_mismatch("result_value", $signed(m_tdata[31:0]),
						head_res.result_value);
				if (m_tdata[33:32] !== head_res.status)
					report_mismatch("status", m_tdata[33:32], head_res.status);
				if (m_tdata[34] !== head_res.now_empty)
					report_mismatch("now_empty", m_tdata[34], head_res.now_empty);
			end
		end
	end

	// watchdog: too long with no transaction on either side
	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d answers owed",
					stuck_cycles, stack_answers.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		pool_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_empty(1'b0);
		test_fill_and_empty(1'b1);
		test_backpressure();
		test_random_traffic(320, 45, 35, RX_ALWAYS, 1'b1);
		test_random_traffic(320, 70, 15, RX_RANDOM, 1'b1);   // mostly full pool
		test_random_traffic(320, 20, 60, RX_PATTERN, 1'b0);  // mostly empty stacks
		test_random_traffic(320, 40, 40, RX_RANDOM, 1'b1);

		// let any stray result show up
		repeat (6) @(posedge clk);

		$display("covered %0d operations: %0d push, %0d pop, %0d top, %0d unused code",
			n_push + n_pop + n_top + n_unused, n_push, n_pop, n_top, n_unused);
		$display("%0d full-pool pushes, %0d empty-stack reads, %0d results checked",
			n_overflow, n_underflow, n_checked);
		if (n_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== k_stacks_shared_pool_unit.f =====
rtl/kssp_pkg.sv
rtl/kssp_pool.sv
rtl/k_stacks_shared_pool_unit.sv
tb/sv/testbench.sv
